// ----- sv/gwp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwp_pkg
// Shared constants, codes and command/status types of the grid wave router.
// ----------------------------------------------------------------------------
package gwp_pkg;

  localparam int GRID_ROWS = 32;
  localparam int GRID_COLS = 32;
  localparam int NCELLS    = GRID_ROWS * GRID_COLS;
  localparam int CELL_W    = $clog2(NCELLS);
  localparam int CNT_W     = CELL_W + 1;
  localparam int DIST_W    = 10;
  localparam int DIM_W     = 6;
  localparam int COORD_W   = 5;

  // request codes
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_SPARE  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_END   = 2'd1;
  localparam logic [1:0] ST_UNREACH   = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  // result kinds
  localparam logic KIND_SEARCH = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef logic [CELL_W-1:0]  cell_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [COORD_W-1:0] coord_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic wclr;     // wall clear sweep step
    logic accept;   // input word taken
    logic chk_s;    // read wall of start
    logic chk_g;    // read wall of goal
    logic lclr;     // label clear sweep step
    logic seed;     // label start, push it
    logic pop_rd;   // read wave queue head
    logic pop_ld;   // load popped cell
    logic nb_rd;    // read neighbor wall and label
    logic nb_ev;    // label and push a free neighbor
    logic t_begin;  // start trace at goal
    logic t_step;   // store path cell, count down
    logic t_rd;     // read neighbor label in trace
    logic t_ev;     // move on a matching neighbor
    logic k_inc;    // next neighbor direction
    logic fin;      // commit path
    logic st_bad;   // endpoint outcome
    logic st_unr;   // unreachable outcome
    logic out_ld;   // load output register
  } gwp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic range_bad;
    logic end_wall;
    logic goal_hit;
    logic fifo_empty;
    logic nb_ok;
    logic k_last;
    logic nb_free;
    logic d_zero;
    logic t_match;
    logic out_free;
  } gwp_stat_t;

  // flat cell address of a grid position
  function automatic cell_t cell_of(input coord_t y, input coord_t x);
    cell_of = CELL_W'(32'(y) * GRID_COLS + 32'(x));
  endfunction

endpackage
`default_nettype wire

// ----- sv/gwp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwp_ctrl
// Sequencer of the wave router: reset sweep, request dispatch, flood,
// trace back and result hand-off.
// ----------------------------------------------------------------------------
module gwp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [1:0]        req_type,
  output logic                   in_stall,
  input  gwp_pkg::gwp_stat_t     stat,
  output gwp_pkg::gwp_cmd_t      cmd
);

  typedef enum logic [15:0] {
    S_CLEAR = 16'h0001,
    S_IDLE  = 16'h0002,
    S_CHK   = 16'h0004,
    S_CHK2  = 16'h0008,
    S_CHK3  = 16'h0010,
    S_LCLR  = 16'h0020,
    S_SEED  = 16'h0040,
    S_POP   = 16'h0080,
    S_POP2  = 16'h0100,
    S_NRD   = 16'h0200,
    S_NEV   = 16'h0400,
    S_TSTEP = 16'h0800,
    S_TRD   = 16'h1000,
    S_TEV   = 16'h2000,
    S_FIN   = 16'h4000,
    S_RES   = 16'h8000
  } state_t;

  state_t state, state_next;

  // take input words only while idle
  assign in_stall = (state != S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.wclr = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (req_type)
            gwp_pkg::REQ_SEARCH: state_next = S_CHK;
            gwp_pkg::REQ_READ:   state_next = S_RES;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_CHK: begin
        if (stat.range_bad) begin
          cmd.st_bad = 1'b1;
          state_next = S_RES;
        end else begin
          cmd.chk_s  = 1'b1;
          state_next = S_CHK2;
        end
      end
      S_CHK2: begin
        cmd.chk_g  = 1'b1;
        state_next = S_CHK3;
      end
      S_CHK3: begin
        if (stat.end_wall) begin
          cmd.st_bad = 1'b1;
          state_next = S_RES;
        end else begin
          state_next = S_LCLR;
        end
      end
      S_LCLR: begin
        cmd.lclr = 1'b1;
        if (stat.clr_last) state_next = S_SEED;
      end
      S_SEED: begin
        cmd.seed   = 1'b1;
        state_next = S_POP;
      end
      S_POP: begin
        if (stat.goal_hit) begin
          cmd.t_begin = 1'b1;
          state_next  = S_TSTEP;
        end else if (stat.fifo_empty) begin
          cmd.st_unr = 1'b1;
          state_next = S_RES;
        end else begin
          cmd.pop_rd = 1'b1;
          state_next = S_POP2;
        end
      end
      S_POP2: begin
        cmd.pop_ld = 1'b1;
        state_next = S_NRD;
      end
      S_NRD: begin
        if (stat.nb_ok) begin
          cmd.nb_rd  = 1'b1;
          state_next = S_NEV;
        end else if (stat.k_last) begin
          state_next = S_POP;
        end else begin
          cmd.k_inc = 1'b1;
        end
      end
      S_NEV: begin
        cmd.nb_ev = 1'b1;
        if (stat.k_last) begin
          state_next = S_POP;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_NRD;
        end
      end
      S_TSTEP: begin
        if (stat.d_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.t_step = 1'b1;
          state_next = S_TRD;
        end
      end
      S_TRD: begin
        if (stat.nb_ok) begin
          cmd.t_rd   = 1'b1;
          state_next = S_TEV;
        end else if (stat.k_last) begin
          state_next = S_TSTEP;
        end else begin
          cmd.k_inc = 1'b1;
        end
      end
      S_TEV: begin
        cmd.t_ev = 1'b1;
        if (stat.t_match || stat.k_last) begin
          state_next = S_TSTEP;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_TRD;
        end
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_RES;
      end
      S_RES: begin
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/gwp_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwp_dpath
// Datapath of the wave router: wall map, distance labels, wave queue and
// path memories, the cursor and neighbor logic, and the output register.
// ----------------------------------------------------------------------------
module gwp_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [gwp_pkg::DIM_W-1:0]     cfg_data,
  input  wire logic [1:0]                    req_type,
  input  wire logic [4:0]                    cell_row,
  input  wire logic [4:0]                    cell_col,
  input  wire logic                          cell_wall,
  input  wire logic [4:0]                    start_x,
  input  wire logic [4:0]                    start_y,
  input  wire logic [4:0]                    goal_x,
  input  wire logic [4:0]                    goal_y,
  input  wire logic [9:0]                    step_index,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output logic                               result_kind,
  output logic [1:0]                         status,
  output logic [9:0]                         path_length,
  output logic [4:0]                         step_x,
  output logic [4:0]                         step_y,
  input  gwp_pkg::gwp_cmd_t                  cmd,
  output gwp_pkg::gwp_stat_t                 stat
);

  localparam int CW = gwp_pkg::CELL_W;
  localparam int DW = gwp_pkg::DIST_W;
  localparam int NW = gwp_pkg::DIM_W;

  // memories
  logic                   wall_mem [gwp_pkg::NCELLS];
  logic [DW:0]            lab_mem  [gwp_pkg::NCELLS];
  logic [CW+DW-1:0]       fifo_mem [gwp_pkg::NCELLS];
  gwp_pkg::cell_t         path_mem [gwp_pkg::NCELLS];

  logic                   wall_rd;
  logic [DW:0]            lab_rd;
  logic [CW+DW-1:0]       fifo_rd;
  gwp_pkg::cell_t         path_rd;

  // registers
  logic [NW-1:0]          used_rows, used_cols;
  gwp_pkg::coord_t        sx, sy, gx, gy;
  logic [9:0]             idx;
  logic                   ws;
  gwp_pkg::cell_t         clr;
  logic [gwp_pkg::CNT_W-1:0] head, tail;
  logic                   goal_hit;
  gwp_pkg::dist_t         glen;
  gwp_pkg::coord_t        cur_x, cur_y;
  gwp_pkg::dist_t         cur_d;
  logic [1:0]             k;
  gwp_pkg::coord_t        nb_x, nb_y;
  gwp_pkg::cell_t         nb_c;
  gwp_pkg::dist_t         stored_length;
  logic                   path_valid;
  logic                   kind;
  logic [1:0]             st;

  // combinational helpers
  logic [NW-1:0]          rows_c, cols_c;
  gwp_pkg::cell_t         s_c, g_c, ld_c, nx_c;
  gwp_pkg::coord_t        nx, ny;
  logic                   nx_ok;
  logic                   ld_ok;
  logic                   wall_we, wall_wd, wall_re, lab_we, lab_re;
  gwp_pkg::cell_t         wall_wa, wall_ra, lab_wa;
  logic [DW:0]            lab_wd;
  gwp_pkg::dist_t         d_inc;
  logic                   out_free;

  // clamp the used area to 1..grid size
  always_comb begin
    rows_c = used_rows;
    if (used_rows == '0) rows_c = NW'(1);
    else if (32'(used_rows) > gwp_pkg::GRID_ROWS) rows_c = NW'(gwp_pkg::GRID_ROWS);
    cols_c = used_cols;
    if (used_cols == '0) cols_c = NW'(1);
    else if (32'(used_cols) > gwp_pkg::GRID_COLS) cols_c = NW'(gwp_pkg::GRID_COLS);
  end

  assign s_c   = gwp_pkg::cell_of(sy, sx);
  assign g_c   = gwp_pkg::cell_of(gy, gx);
  assign ld_c  = gwp_pkg::cell_of(cell_row, cell_col);
  assign ld_ok = (32'(cell_row) < gwp_pkg::GRID_ROWS) && (32'(cell_col) < gwp_pkg::GRID_COLS);
  assign d_inc = cur_d + DW'(1);

  // neighbor of the cursor in direction k: right, down, left, up
  always_comb begin
    nx    = cur_x;
    ny    = cur_y;
    nx_ok = 1'b0;
    case (k)
      2'd0: begin
        nx_ok = ({1'b0, cur_x} + NW'(1)) < cols_c;
        nx    = cur_x + 5'd1;
      end
      2'd1: begin
        nx_ok = ({1'b0, cur_y} + NW'(1)) < rows_c;
        ny    = cur_y + 5'd1;
      end
      2'd2: begin
        nx_ok = (cur_x != '0);
        nx    = cur_x - 5'd1;
      end
      default: begin
        nx_ok = (cur_y != '0);
        ny    = cur_y - 5'd1;
      end
    endcase
  end
  assign nx_c = gwp_pkg::cell_of(ny, nx);

  // status to the controller
  assign out_free = !out_valid || !out_stall;
  always_comb begin
    stat.clr_last   = (clr == CW'(gwp_pkg::NCELLS - 1));
    stat.range_bad  = ({1'b0, sx} >= cols_c) || ({1'b0, sy} >= rows_c) ||
                      ({1'b0, gx} >= cols_c) || ({1'b0, gy} >= rows_c);
    stat.end_wall   = ws || wall_rd;
    stat.goal_hit   = goal_hit;
    stat.fifo_empty = (head == tail);
    stat.nb_ok      = nx_ok;
    stat.k_last     = (k == 2'd3);
    stat.nb_free    = !wall_rd && !lab_rd[DW];
    stat.d_zero     = (cur_d == '0);
    stat.t_match    = lab_rd[DW] && (lab_rd[DW-1:0] == cur_d);
    stat.out_free   = out_free;
  end

  // wall map port steering
  always_comb begin
    wall_we = cmd.wclr || (cmd.accept && req_type == gwp_pkg::REQ_LOAD && ld_ok);
    wall_wa = cmd.wclr ? clr : ld_c;
    wall_wd = cmd.wclr ? 1'b0 : cell_wall;
    wall_re = cmd.chk_s || cmd.chk_g || cmd.nb_rd;
    wall_ra = cmd.chk_s ? s_c : (cmd.chk_g ? g_c : nx_c);
  end

  always_ff @(posedge clk) begin
    if (wall_we) wall_mem[wall_wa] <= wall_wd;
    if (wall_re) wall_rd <= wall_mem[wall_ra];
  end

  // label port steering
  always_comb begin
    lab_we = cmd.lclr || cmd.seed || (cmd.nb_ev && stat.nb_free);
    lab_wa = nb_c;
    lab_wd = {1'b1, d_inc};
    if (cmd.lclr) begin
      lab_wa = clr;
      lab_wd = '0;
    end else if (cmd.seed) begin
      lab_wa = s_c;
      lab_wd = {1'b1, {DW{1'b0}}};
    end
    lab_re = cmd.nb_rd || cmd.t_rd;
  end

  always_ff @(posedge clk) begin
    if (lab_we) lab_mem[lab_wa] <= lab_wd;
    if (lab_re) lab_rd <= lab_mem[nx_c];
  end

  // wave queue
  always_ff @(posedge clk) begin
    if (cmd.seed) fifo_mem[CW'(0)] <= {s_c, {DW{1'b0}}};
    else if (cmd.nb_ev && stat.nb_free) fifo_mem[tail[CW-1:0]] <= {nb_c, d_inc};
    if (cmd.pop_rd) fifo_rd <= fifo_mem[head[CW-1:0]];
  end

  // path store
  always_ff @(posedge clk) begin
    if (cmd.t_step) path_mem[cur_d[CW-1:0]] <= gwp_pkg::cell_of(cur_y, cur_x);
    else if (cmd.fin) path_mem[CW'(0)] <= s_c;
    if (cmd.accept && req_type == gwp_pkg::REQ_READ) path_rd <= path_mem[step_index[CW-1:0]];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      used_rows <= NW'(20);
      used_cols <= NW'(25);
    end else if (cfg_we) begin
      if (cfg_index == gwp_pkg::CFG_ROWS) used_rows <= cfg_data;
      if (cfg_index == gwp_pkg::CFG_COLS) used_cols <= cfg_data;
    end
  end

  // sweep counter shared by wall and label clearing
  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.wclr || cmd.lclr) begin
      clr <= stat.clr_last ? '0 : clr + CW'(1);
    end
  end

  // request latch, flood and trace registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sx  <= start_x;
      sy  <= start_y;
      gx  <= goal_x;
      gy  <= goal_y;
      idx <= step_index;
    end
    if (cmd.chk_g) ws <= wall_rd;
    if (cmd.nb_rd || cmd.t_rd) begin
      nb_x <= nx;
      nb_y <= ny;
      nb_c <= nx_c;
    end
    if (cmd.pop_ld) begin
      cur_x <= gwp_pkg::coord_t'(fifo_rd[DW +: CW] % gwp_pkg::GRID_COLS);
      cur_y <= gwp_pkg::coord_t'(fifo_rd[DW +: CW] / gwp_pkg::GRID_COLS);
      cur_d <= fifo_rd[DW-1:0];
    end else if (cmd.t_begin) begin
      cur_x <= gx;
      cur_y <= gy;
      cur_d <= glen;
    end else if (cmd.t_step) begin
      cur_d <= cur_d - DW'(1);
    end else if (cmd.t_ev && stat.t_match) begin
      cur_x <= nb_x;
      cur_y <= nb_y;
    end
  end

  // queue pointers, goal flag and direction counter
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      goal_hit <= 1'b0;
      glen     <= '0;
      k        <= '0;
    end else begin
      if (cmd.seed) begin
        head     <= '0;
        tail     <= gwp_pkg::CNT_W'(1);
        goal_hit <= (s_c == g_c);
        glen     <= '0;
      end
      if (cmd.pop_rd) head <= head + gwp_pkg::CNT_W'(1);
      if (cmd.nb_ev && stat.nb_free) begin
        tail <= tail + gwp_pkg::CNT_W'(1);
        if (nb_c == g_c) begin
          goal_hit <= 1'b1;
          glen     <= d_inc;
        end
      end
      if (cmd.pop_ld || cmd.t_step) k <= '0;
      else if (cmd.k_inc) k <= k + 2'd1;
    end
  end

  // stored path summary and pending outcome
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_length <= '0;
      path_valid    <= 1'b0;
      kind          <= gwp_pkg::KIND_SEARCH;
      st            <= gwp_pkg::ST_OK;
    end else begin
      if (cmd.accept) begin
        kind <= (req_type == gwp_pkg::REQ_READ) ? gwp_pkg::KIND_READ : gwp_pkg::KIND_SEARCH;
      end
      if (cmd.fin) begin
        stored_length <= glen;
        path_valid    <= 1'b1;
        st            <= gwp_pkg::ST_OK;
      end else if (cmd.st_bad) begin
        st <= gwp_pkg::ST_BAD_END;
      end else if (cmd.st_unr) begin
        st <= gwp_pkg::ST_UNREACH;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      result_kind <= kind;
      path_length <= path_valid ? stored_length : '0;
      step_x      <= '0;
      step_y      <= '0;
      if (kind == gwp_pkg::KIND_READ) begin
        if (!path_valid || idx > stored_length) begin
          status <= gwp_pkg::ST_BAD_INDEX;
        end else begin
          status <= gwp_pkg::ST_OK;
          step_x <= gwp_pkg::coord_t'(path_rd % gwp_pkg::GRID_COLS);
          step_y <= gwp_pkg::coord_t'(path_rd / gwp_pkg::GRID_COLS);
        end
      end else begin
        status <= st;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/grid_wave_path_finder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_wave_path_finder_unit
// Lee wave router on a four-neighbor grid of wall bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_valid/in_stall; req_type selects a wall load,
//   a search or a path step read. Results leave on out_valid/out_stall, one
//   word per search or read, none per load. used_rows/used_cols are written
//   through cfg_we/cfg_index/cfg_data; the user must write them only while
//   the block is idle, the block itself does not enforce it.
//   Request handling, one word at a time:
//     load   - written on accept; the block stays idle for the next word.
//     read   - the path memory is read on accept and the result is
//              registered from S_RES once the output register is free.
//     search - endpoint checks, a label clear sweep (one label per cycle),
//              then the flood and the trace back; each neighbor visit
//              costs a memory read and an evaluate state.
//   Reset: a sweep over every cell clears the wall map; in_stall stays high
//   until it ends. No path is stored after reset.
//   Receiver stall: the finished word holds in the output register; the block
//   still takes loads, and a further result waits until the register frees.
// ----------------------------------------------------------------------------
module grid_wave_path_finder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [5:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [4:0]  cell_row,
  input  wire logic [4:0]  cell_col,
  input  wire logic        cell_wall,
  input  wire logic [4:0]  start_x,
  input  wire logic [4:0]  start_y,
  input  wire logic [4:0]  goal_x,
  input  wire logic [4:0]  goal_y,
  input  wire logic [9:0]  step_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             result_kind,
  output logic [1:0]       status,
  output logic [9:0]       path_length,
  output logic [4:0]       step_x,
  output logic [4:0]       step_y
);

  gwp_pkg::gwp_cmd_t  cmd;
  gwp_pkg::gwp_stat_t stat;

  // sequencer
  gwp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stores and arithmetic
  gwp_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_type    (req_type),
    .cell_row    (cell_row),
    .cell_col    (cell_col),
    .cell_wall   (cell_wall),
    .start_x     (start_x),
    .start_y     (start_y),
    .goal_x      (goal_x),
    .goal_y      (goal_y),
    .step_index  (step_index),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .result_kind (result_kind),
    .status      (status),
    .path_length (path_length),
    .step_x      (step_x),
    .step_y      (step_y),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule
`default_nettype wire

// ----- sv/gwp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwp_checker
// Port-level checks of the wave router result channel.
// ----------------------------------------------------------------------------
module gwp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       result_kind,
  input wire logic [1:0] status,
  input wire logic [4:0] step_x,
  input wire logic [4:0] step_y
);

  // hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_kind))
    else $error("stalled result word changed");

  // search outcomes carry no coordinates
  a_search_xy: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == gwp_pkg::KIND_SEARCH |-> step_x == '0 && step_y == '0)
    else $error("search outcome with nonzero step");

  // reads report either ok or index beyond path
  a_read_st: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == gwp_pkg::KIND_READ |->
      status == gwp_pkg::ST_OK || status == gwp_pkg::ST_BAD_INDEX)
    else $error("read word with search status");

  // failed reads carry zero coordinates
  a_read_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == gwp_pkg::KIND_READ && status == gwp_pkg::ST_BAD_INDEX |->
      step_x == '0 && step_y == '0)
    else $error("failed read with nonzero step");

endmodule

bind grid_wave_path_finder_unit gwp_checker u_gwp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .result_kind (result_kind),
  .status      (status),
  .step_x      (step_x),
  .step_y      (step_y)
);
`default_nettype wire
